@@ hdl/ilse_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ilse_pkg
// Shared request and status codes, widths and the response bundle of the
// indexed list store engine.
// ----------------------------------------------------------------------------
package ilse_pkg;

  localparam int TYPE_W   = 3;
  localparam int STATUS_W = 2;
  localparam int DATA_W   = 32;

  // Value returned by a find that misses and a read at a bad index
  localparam logic [DATA_W-1:0] RES_MISS = '1;

  typedef enum logic [TYPE_W-1:0] {
    OP_PUSH    = 3'd0,
    OP_INSERT  = 3'd1,
    OP_PREPEND = 3'd2,
    OP_POP     = 3'd3,
    OP_DELETE  = 3'd4,
    OP_REMOVE  = 3'd5,
    OP_FIND    = 3'd6,
    OP_READ    = 3'd7
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_e;

  // Response handed from the sequencer to the output register
  typedef struct packed {
    status_e             status;
    logic [DATA_W-1:0]   result_value;
  } resp_t;

endpackage
`default_nettype wire

@@ hdl/ilse_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ilse_mem
// Entry store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ilse_mem #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic                        clk_i,
  input  wire logic                        we_i,
  input  wire logic [ADDR_W-1:0]           waddr_i,
  input  wire logic [ilse_pkg::DATA_W-1:0] wdata_i,
  input  wire logic                        re_i,
  input  wire logic [ADDR_W-1:0]           raddr_i,
  output logic      [ilse_pkg::DATA_W-1:0] rdata_o
);

  logic [ilse_pkg::DATA_W-1:0] mem_q [DEPTH];
  logic [ilse_pkg::DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ hdl/ilse_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ilse_ctrl
// Request sequencer: checks the request against the count, walks the store
// one entry per cycle through the memory port and moves, compacts or
// compares entries, then hands the response to the output register.
// ----------------------------------------------------------------------------
module ilse_ctrl #(
  parameter int DEPTH  = 256,
  parameter int CNT_W  = $clog2(DEPTH + 1),
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // request side
  input  wire logic                        req_valid_i,
  output logic                             req_ready_o,
  input  wire ilse_pkg::op_e               req_op_i,
  input  wire logic [CNT_W-1:0]            req_pos_i,
  input  wire logic [ilse_pkg::DATA_W-1:0] req_val_i,
  // memory port
  output logic                             mem_we_o,
  output logic      [ADDR_W-1:0]           mem_waddr_o,
  output logic      [ilse_pkg::DATA_W-1:0] mem_wdata_o,
  output logic                             mem_re_o,
  output logic      [ADDR_W-1:0]           mem_raddr_o,
  input  wire logic [ilse_pkg::DATA_W-1:0] mem_rdata_i,
  // response side
  input  wire logic                        out_free_i,
  output logic                             out_load_o,
  output ilse_pkg::resp_t                  out_resp_o,
  output logic      [CNT_W-1:0]            out_count_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;
  localparam logic [1:0] S_RESP = 2'd3;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  logic [1:0]                  state_q, state_d;
  ilse_pkg::op_e               op_q, op_d;
  logic [CNT_W-1:0]            pos_q, pos_d;
  logic [ilse_pkg::DATA_W-1:0] val_q, val_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic [CNT_W-1:0]            idx_q, idx_d;
  logic [CNT_W-1:0]            rem_q, rem_d;
  logic [CNT_W-1:0]            kept_q, kept_d;
  logic                        pend_q, pend_d;
  logic [CNT_W-1:0]            pend_idx_q, pend_idx_d;
  logic                        found_q, found_d;
  ilse_pkg::status_e           status_q, status_d;
  logic [ilse_pkg::DATA_W-1:0] result_q, result_d;

  logic             accept;
  logic             walk_down;
  logic             hit;
  logic             issue;
  logic [CNT_W-1:0] waddr;

  assign accept    = (state_q == S_IDLE) && req_valid_i;
  assign walk_down = (op_q == ilse_pkg::OP_INSERT) || (op_q == ilse_pkg::OP_PREPEND);

  // first match of a find, ignoring reads still in flight after it
  assign hit   = pend_q && !found_q && (op_q == ilse_pkg::OP_FIND) &&
                 (mem_rdata_i == val_q);
  assign issue = (state_q == S_SCAN) && (rem_q != '0) && !found_q && !hit;

  assign mem_re_o    = issue;
  assign mem_raddr_o = idx_q[ADDR_W-1:0];
  assign mem_waddr_o = waddr[ADDR_W-1:0];

  assign req_ready_o = (state_q == S_IDLE);
  assign out_load_o  = (state_q == S_RESP) && out_free_i;
  assign out_count_o = cnt_q;
  assign out_resp_o  = '{status: status_q, result_value: result_q};

  // sequencer next state
  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    pos_d      = pos_q;
    val_d      = val_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    rem_d      = rem_q;
    kept_d     = kept_q;
    pend_d     = 1'b0;
    pend_idx_d = pend_idx_q;
    found_d    = found_q;
    status_d   = status_q;
    result_d   = result_q;
    mem_we_o    = 1'b0;
    waddr       = '0;
    mem_wdata_o = mem_rdata_i;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d     = req_op_i;
          pos_d    = req_pos_i;
          val_d    = req_val_i;
          kept_d   = '0;
          found_d  = 1'b0;
          status_d = ilse_pkg::ST_DONE;
          result_d = '0;
          idx_d    = '0;
          rem_d    = '0;
          state_d  = S_SCAN;
          case (req_op_i)
            ilse_pkg::OP_PUSH: begin
              if (cnt_q == CNT_FULL) begin
                status_d = ilse_pkg::ST_FULL;
                state_d  = S_RESP;
              end
            end
            ilse_pkg::OP_INSERT: begin
              if (req_pos_i > cnt_q) begin
                status_d = ilse_pkg::ST_BAD;
                state_d  = S_RESP;
              end else if (cnt_q == CNT_FULL) begin
                status_d = ilse_pkg::ST_FULL;
                state_d  = S_RESP;
              end else begin
                idx_d = cnt_q - CNT_ONE;
                rem_d = cnt_q - req_pos_i;
              end
            end
            ilse_pkg::OP_PREPEND: begin
              pos_d = '0;
              if (cnt_q == CNT_FULL) begin
                status_d = ilse_pkg::ST_FULL;
                state_d  = S_RESP;
              end else begin
                idx_d = cnt_q - CNT_ONE;
                rem_d = cnt_q;
              end
            end
            ilse_pkg::OP_POP: begin
              if (cnt_q == '0) begin
                status_d = ilse_pkg::ST_BAD;
                state_d  = S_RESP;
              end else begin
                idx_d = cnt_q - CNT_ONE;
                rem_d = CNT_ONE;
              end
            end
            ilse_pkg::OP_DELETE: begin
              if (req_pos_i >= cnt_q) begin
                status_d = ilse_pkg::ST_BAD;
                state_d  = S_RESP;
              end else begin
                idx_d = req_pos_i + CNT_ONE;
                rem_d = cnt_q - req_pos_i - CNT_ONE;
              end
            end
            ilse_pkg::OP_REMOVE: begin
              rem_d = cnt_q;
            end
            ilse_pkg::OP_FIND: begin
              status_d = ilse_pkg::ST_BAD;
              result_d = ilse_pkg::RES_MISS;
              rem_d    = cnt_q;
            end
            default: begin // read at
              if (req_pos_i >= cnt_q) begin
                status_d = ilse_pkg::ST_BAD;
                result_d = ilse_pkg::RES_MISS;
                state_d  = S_RESP;
              end else begin
                idx_d = req_pos_i;
                rem_d = CNT_ONE;
              end
            end
          endcase
        end
      end

      S_SCAN: begin
        // issue the next read
        if (issue) begin
          pend_d     = 1'b1;
          pend_idx_d = idx_q;
          rem_d      = rem_q - CNT_ONE;
          idx_d      = walk_down ? (idx_q - CNT_ONE) : (idx_q + CNT_ONE);
        end
        // act on the word read last cycle
        if (pend_q) begin
          case (op_q)
            ilse_pkg::OP_INSERT, ilse_pkg::OP_PREPEND: begin
              mem_we_o = 1'b1;
              waddr    = pend_idx_q + CNT_ONE;
            end
            ilse_pkg::OP_DELETE: begin
              mem_we_o = 1'b1;
              waddr    = pend_idx_q - CNT_ONE;
            end
            ilse_pkg::OP_REMOVE: begin
              if (mem_rdata_i != val_q) begin
                mem_we_o = 1'b1;
                waddr    = kept_q;
                kept_d   = kept_q + CNT_ONE;
              end
            end
            ilse_pkg::OP_FIND: begin
              if (hit) begin
                found_d  = 1'b1;
                status_d = ilse_pkg::ST_DONE;
                result_d = ilse_pkg::DATA_W'(pend_idx_q);
              end
            end
            ilse_pkg::OP_POP, ilse_pkg::OP_READ: begin
              result_d = mem_rdata_i;
            end
            default: begin
            end
          endcase
        end
        if (!issue && !pend_q) begin
          state_d = S_FIN;
        end
      end

      S_FIN: begin
        // final store write and count update
        mem_wdata_o = val_q;
        state_d     = S_RESP;
        case (op_q)
          ilse_pkg::OP_PUSH: begin
            mem_we_o = 1'b1;
            waddr    = cnt_q;
            cnt_d    = cnt_q + CNT_ONE;
          end
          ilse_pkg::OP_INSERT, ilse_pkg::OP_PREPEND: begin
            mem_we_o = 1'b1;
            waddr    = pos_q;
            cnt_d    = cnt_q + CNT_ONE;
          end
          ilse_pkg::OP_POP, ilse_pkg::OP_DELETE: begin
            cnt_d = cnt_q - CNT_ONE;
          end
          ilse_pkg::OP_REMOVE: begin
            cnt_d = kept_q;
          end
          default: begin
          end
        endcase
      end

      S_RESP: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      found_q <= 1'b0;
      rem_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      found_q <= found_d;
      rem_q   <= rem_d;
    end
  end

  // request and working registers
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    pos_q      <= pos_d;
    val_q      <= val_d;
    idx_q      <= idx_d;
    kept_q     <= kept_d;
    pend_idx_q <= pend_idx_d;
    status_q   <= status_d;
    result_q   <= result_d;
  end

endmodule
`default_nettype wire

@@ hdl/ilse_out.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ilse_out
// Output register: holds one response word until the receiver takes it.
// ----------------------------------------------------------------------------
module ilse_out #(
  parameter int CNT_W = 9
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        load_i,
  input  wire ilse_pkg::resp_t             resp_i,
  input  wire logic [CNT_W-1:0]            count_i,
  output logic                             free_o,
  output logic                             valid_o,
  input  wire logic                        ready_i,
  output ilse_pkg::status_e                status_o,
  output logic      [ilse_pkg::DATA_W-1:0] result_value_o,
  output logic      [CNT_W-1:0]            list_count_o,
  output logic                             is_empty_o
);

  logic              valid_q;
  ilse_pkg::resp_t   resp_q;
  logic [CNT_W-1:0]  count_q;

  assign free_o = !valid_q || ready_i;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      resp_q  <= resp_i;
      count_q <= count_i;
    end
  end

  assign valid_o        = valid_q;
  assign status_o       = resp_q.status;
  assign result_value_o = resp_q.result_value;
  assign list_count_o   = count_q;
  assign is_empty_o     = (count_q == '0);

endmodule
`default_nettype wire

@@ hdl/indexed_list_store_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_list_store_engine
// Ordered list of signed 32-bit words in a DEPTH-entry store with a count.
// ----------------------------------------------------------------------------
// Usage:
//   Requests come in on the s_axis group: tuser carries the request type,
//   tdata the position and the item. Each request gives exactly one result
//   word on the m_axis group: tuser carries the status, tdata the value, the
//   new count and the empty flag.
//   One request is worked at a time; s_axis_tready is high only while the
//   sequencer is idle. A request reads its entries one at a time through the
//   single memory read port before its result word is loaded: one entry for
//   pop and read, the tail for insert, prepend and delete, the whole count
//   for remove and find, up to and including the hit for a find that hits;
//   push reads none, and no request reads more than DEPTH. Rejected requests
//   read none and go straight to the response state. The next request can
//   be taken in the cycle after the result word is loaded.
//   A result word waits in the output register while the next request is
//   already taken; the sequencer holds the following result, and takes no
//   new request, until the register frees up.
//   Reset empties the list; the store itself needs no clearing.
// ----------------------------------------------------------------------------
module indexed_list_store_engine #(
  parameter int DEPTH = 256,
  localparam int CNT_W  = $clog2(DEPTH + 1),
  localparam int IN_DW  = ((CNT_W + ilse_pkg::DATA_W + 7) / 8) * 8,
  localparam int OUT_DW = ((ilse_pkg::DATA_W + CNT_W + 1 + 7) / 8) * 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // request stream
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [IN_DW-1:0]              s_axis_tdata,  // position, item
  input  wire logic [ilse_pkg::TYPE_W-1:0]   s_axis_tuser,  // req_type
  // result stream
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic      [OUT_DW-1:0]             m_axis_tdata,  // result_value, list_count, is_empty
  output logic      [ilse_pkg::STATUS_W-1:0] m_axis_tuser   // status
);

  localparam int ADDR_W = $clog2(DEPTH);

  logic                        mem_we;
  logic [ADDR_W-1:0]           mem_waddr;
  logic [ilse_pkg::DATA_W-1:0] mem_wdata;
  logic                        mem_re;
  logic [ADDR_W-1:0]           mem_raddr;
  logic [ilse_pkg::DATA_W-1:0] mem_rdata;

  logic                        out_free;
  logic                        out_load;
  ilse_pkg::resp_t             out_resp;
  logic [CNT_W-1:0]            out_count;

  ilse_pkg::status_e           res_status;
  logic [ilse_pkg::DATA_W-1:0] res_value;
  logic [CNT_W-1:0]            res_count;
  logic                        res_empty;

  // entry store
  ilse_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // request sequencer
  ilse_ctrl #(
    .DEPTH  (DEPTH),
    .CNT_W  (CNT_W),
    .ADDR_W (ADDR_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_op_i    (ilse_pkg::op_e'(s_axis_tuser)),
    .req_pos_i   (s_axis_tdata[CNT_W-1:0]),
    .req_val_i   (s_axis_tdata[CNT_W +: ilse_pkg::DATA_W]),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .out_free_i  (out_free),
    .out_load_o  (out_load),
    .out_resp_o  (out_resp),
    .out_count_o (out_count)
  );

  // result register
  ilse_out #(
    .CNT_W (CNT_W)
  ) u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (out_load),
    .resp_i         (out_resp),
    .count_i        (out_count),
    .free_o         (out_free),
    .valid_o        (m_axis_tvalid),
    .ready_i        (m_axis_tready),
    .status_o       (res_status),
    .result_value_o (res_value),
    .list_count_o   (res_count),
    .is_empty_o     (res_empty)
  );

  // pack the result word
  assign m_axis_tuser = res_status;
  assign m_axis_tdata = OUT_DW'({res_empty, res_count, res_value});

endmodule
`default_nettype wire

@@ bench/indexed_list_store_engine_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_store_engine_test
// Self-checking bench for the indexed list store engine. A scoreboard keeps
// its own copy of the list and works out the reply to each accepted request.
// Replies are compared field by field in order. Directed requests cover the
// empty and full cases and the bad indexes. Random phases then grow, shrink
// and fill the list, with idle bursts on both streams.
// ----------------------------------------------------------------------------
module indexed_list_store_engine_test;

  localparam int          DEPTH       = 256;
  localparam int          CNT_W       = 9;
  localparam int          IN_DW       = 48;
  localparam int          OUT_DW      = 48;
  localparam int unsigned ITEM_TARGET = 1900;
  localparam int unsigned CALM_TAIL   = 200;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;

  // Expected reply of one request
  typedef struct packed {
    ilse_pkg::status_e           status;
    logic [ilse_pkg::DATA_W-1:0] value;
    logic [CNT_W-1:0]            count;
    logic                        empty;
  } list_reply_t;

  typedef enum int {PH_GROW, PH_SHRINK, PH_MIXED} phase_e;

  // --------------------------------------------------------------------------
  // Scoreboard: mirror of the list and the queue of replies still due
  // --------------------------------------------------------------------------
  class list_scoreboard;
    logic [ilse_pkg::DATA_W-1:0] entries [DEPTH];
    int unsigned                 n_entries;
    list_reply_t                 replies_due [$];
    int unsigned                 n_faults;

    function void report_fault(string msg);
      n_faults++;
      if (n_faults <= 10) $display("%0t: %s", $time, msg);
    endfunction

    // Update the mirror for an accepted request and queue its reply
    function void apply_request(ilse_pkg::op_e op, logic [CNT_W-1:0] pos,
                                logic [ilse_pkg::DATA_W-1:0] val);
      list_reply_t r;
      int unsigned i;
      int unsigned kept;
      int unsigned at;
      r.status = ilse_pkg::ST_DONE;
      r.value  = '0;
      case (op)
        ilse_pkg::OP_PUSH: begin
          if (n_entries == DEPTH) begin
            r.status = ilse_pkg::ST_FULL;
          end else begin
            entries[n_entries] = val;
            n_entries++;
          end
        end
        ilse_pkg::OP_INSERT, ilse_pkg::OP_PREPEND: begin
          at = (op == ilse_pkg::OP_PREPEND) ? 0 : pos;
          // index check wins over the full check
          if (at > n_entries) begin
            r.status = ilse_pkg::ST_BAD;
          end else if (n_entries == DEPTH) begin
            r.status = ilse_pkg::ST_FULL;
          end else begin
            for (i = n_entries; i > at; i--) entries[i] = entries[i-1];
            entries[at] = val;
            n_entries++;
          end
        end
        ilse_pkg::OP_POP: begin
          if (n_entries == 0) begin
            r.status = ilse_pkg::ST_BAD;
          end else begin
            n_entries--;
            r.value = entries[n_entries];
          end
        end
        ilse_pkg::OP_DELETE: begin
          if (pos >= n_entries) begin
            r.status = ilse_pkg::ST_BAD;
          end else begin
            for (i = pos + 1; i < n_entries; i++) entries[i-1] = entries[i];
            n_entries--;
          end
        end
        ilse_pkg::OP_REMOVE: begin
          kept = 0;
          for (i = 0; i < n_entries; i++) begin
            if (entries[i] != val) begin
              entries[kept] = entries[i];
              kept++;
            end
          end
          n_entries = kept;
        end
        ilse_pkg::OP_FIND: begin
          r.status = ilse_pkg::ST_BAD;
          r.value  = ilse_pkg::RES_MISS;
          for (i = 0; i < n_entries; i++) begin
            if (entries[i] == val) begin
              r.status = ilse_pkg::ST_DONE;
              r.value  = ilse_pkg::DATA_W'(i);
              break;
            end
          end
        end
        default: begin
          if (pos >= n_entries) begin
            r.status = ilse_pkg::ST_BAD;
            r.value  = ilse_pkg::RES_MISS;
          end else begin
            r.value = entries[pos];
          end
        end
      endcase
      r.count = CNT_W'(n_entries);
      r.empty = (n_entries == 0);
      replies_due.push_back(r);
    endfunction

    // Compare one reply word with the oldest one due
    function void check_reply(logic [ilse_pkg::STATUS_W-1:0] st, logic [OUT_DW-1:0] data);
      list_reply_t e;
      if (replies_due.size() == 0) begin
        report_fault($sformatf("unexpected reply: status %0d value %h count %0d empty %0b",
                               st, data[31:0], data[40:32], data[41]));
        return;
      end
      e = replies_due.pop_front();
      if (st !== e.status || data[31:0] !== e.value || data[40:32] !== e.count ||
          data[41] !== e.empty)
        report_fault($sformatf(
          "reply mismatch: exp status %0d value %h count %0d empty %0b, got %0d %h %0d %0b",
          e.status, e.value, e.count, e.empty, st, data[31:0], data[40:32], data[41]));
    endfunction

    function int unsigned pending();
      return replies_due.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [IN_DW-1:0]              s_axis_tdata = '0;  // position [8:0], item [40:9]
  logic [ilse_pkg::TYPE_W-1:0]   s_axis_tuser = '0;  // req_type
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [OUT_DW-1:0]             m_axis_tdata;  // result_value [31:0], list_count [40:32],
                                                // is_empty [41]
  logic [ilse_pkg::STATUS_W-1:0] m_axis_tuser;  // status

  list_scoreboard sb = new();

  int unsigned n_sent;
  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  int unsigned rx_hold = 0;
  int unsigned cycle_count = 0;
  bit          calm;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  indexed_list_store_engine #(.DEPTH(DEPTH)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Receiver: ready, with random stall bursts
  always @(posedge clk_i) begin
    if (rx_hold != 0) begin
      rx_hold       <= rx_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < rx_stall_pct) begin
      rx_hold       <= $urandom_range(0, 10);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Reply monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_reply(m_axis_tuser, m_axis_tdata);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Request driving
  // --------------------------------------------------------------------------
  // One request word; returns at the edge that accepts it
  task automatic send_req(ilse_pkg::op_e op, logic [CNT_W-1:0] pos,
                          logic [ilse_pkg::DATA_W-1:0] val);
    if (!calm && $urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {7'b0, val, pos};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.apply_request(op, pos, val);
    n_sent++;
  endtask

  // Hold off until every reply due has come back
  task automatic wait_replies();
    if (sb.pending() != 0) begin
      s_axis_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clk_i);
    end
  endtask

  // Small value set, so finds hit and removes catch duplicates
  function automatic logic [ilse_pkg::DATA_W-1:0] pool_value();
    return 32'($urandom_range(0, 11)) - 32'd6;
  endfunction

  function automatic logic [ilse_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      4, 5, 6: return pool_value();
      default: return $urandom();
    endcase
  endfunction

  // Mostly valid indexes, some at and past the end
  function automatic logic [CNT_W-1:0] pick_pos(int unsigned c, bit end_ok);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CNT_W'(c);
      2:       return (c < DEPTH) ? CNT_W'(c + 1) : CNT_W'(DEPTH);
      3:       return CNT_W'($urandom_range(c, DEPTH));
      default: begin
        if (end_ok) return CNT_W'($urandom_range(0, c));
        return (c == 0) ? '0 : CNT_W'($urandom_range(0, c - 1));
      end
    endcase
  endfunction

  function automatic ilse_pkg::op_e pick_op(phase_e ph);
    int unsigned w [8];
    int unsigned r;
    int unsigned acc;
    case (ph)
      PH_GROW:   w = '{30, 25, 15, 5, 5, 3, 10, 7};
      PH_SHRINK: w = '{5, 5, 3, 25, 25, 12, 12, 13};
      default:   w = '{12, 13, 12, 13, 12, 12, 13, 13};
    endcase
    r   = $urandom_range(0, 99);
    acc = 0;
    for (int k = 0; k < 8; k++) begin
      acc += w[k];
      if (r < acc) return ilse_pkg::op_e'(k);
    end
    return ilse_pkg::OP_READ;
  endfunction

  task automatic send_random(phase_e ph);
    ilse_pkg::op_e               op;
    int unsigned                 c;
    logic [CNT_W-1:0]            pos;
    logic [ilse_pkg::DATA_W-1:0] val;
    op = pick_op(ph);
    c  = sb.n_entries;
    case (op)
      ilse_pkg::OP_INSERT:                    pos = pick_pos(c, 1'b1);
      ilse_pkg::OP_DELETE, ilse_pkg::OP_READ: pos = pick_pos(c, 1'b0);
      default:                                pos = CNT_W'($urandom_range(0, DEPTH));
    endcase
    // finds and removes mostly target a value that is in the list
    if ((op == ilse_pkg::OP_FIND || op == ilse_pkg::OP_REMOVE) && c != 0 &&
        $urandom_range(0, 2) != 0)
      val = sb.entries[$urandom_range(0, c - 1)];
    else
      val = pick_value();
    send_req(op, pos, val);
  endtask

  // Fill the store, hit it while full, then cut it back down
  task automatic fill_store();
    while (sb.n_entries < DEPTH)
      send_req(ilse_pkg::OP_PUSH, CNT_W'($urandom_range(0, DEPTH)), pool_value());
    send_req(ilse_pkg::OP_PUSH, 9'd0, $urandom());
    send_req(ilse_pkg::OP_PREPEND, 9'd3, $urandom());
    send_req(ilse_pkg::OP_INSERT, 9'd256, $urandom());
    send_req(ilse_pkg::OP_INSERT, CNT_W'($urandom_range(0, DEPTH - 1)), $urandom());
    send_req(ilse_pkg::OP_READ, 9'd255, '0);
    send_req(ilse_pkg::OP_READ, 9'd256, '0);
    send_req(ilse_pkg::OP_FIND, 9'd0, pool_value());
    send_req(ilse_pkg::OP_DELETE, 9'd255, '0);
    send_req(ilse_pkg::OP_PREPEND, 9'd0, 32'h7FFF_FFFF);
    send_req(ilse_pkg::OP_POP, 9'd0, '0);
    while (sb.n_entries > 64) send_req(ilse_pkg::OP_REMOVE, 9'd0, pool_value());
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    phase_e ph;
    int unsigned len;
    bit filled;
    n_sent       = 0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    calm         = 1'b0;
    filled       = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty list, ends of the index range, extremes of the item
    send_req(ilse_pkg::OP_POP,     9'd0,   '0);
    send_req(ilse_pkg::OP_DELETE,  9'd0,   '0);
    send_req(ilse_pkg::OP_READ,    9'd0,   '0);
    send_req(ilse_pkg::OP_FIND,    9'd0,   32'd0);
    send_req(ilse_pkg::OP_REMOVE,  9'd0,   32'd0);
    send_req(ilse_pkg::OP_INSERT,  9'd1,   32'd9);
    send_req(ilse_pkg::OP_INSERT,  9'd0,   32'd9);
    send_req(ilse_pkg::OP_PUSH,    9'd0,   32'h7FFF_FFFF);
    send_req(ilse_pkg::OP_PREPEND, 9'd0,   32'h8000_0000);
    send_req(ilse_pkg::OP_PUSH,    9'd0,   32'hFFFF_FFFF);
    send_req(ilse_pkg::OP_INSERT,  9'd4,   32'd0);
    send_req(ilse_pkg::OP_INSERT,  9'd1,   32'd5);
    send_req(ilse_pkg::OP_PUSH,    9'd0,   32'd5);
    send_req(ilse_pkg::OP_READ,    9'd0,   '0);
    send_req(ilse_pkg::OP_READ,    9'd256, '0);
    send_req(ilse_pkg::OP_READ,    9'd7,   '0);
    send_req(ilse_pkg::OP_FIND,    9'd0,   32'd5);
    send_req(ilse_pkg::OP_FIND,    9'd0,   32'd12345);
    send_req(ilse_pkg::OP_DELETE,  9'd0,   '0);
    send_req(ilse_pkg::OP_DELETE,  9'd256, '0);
    send_req(ilse_pkg::OP_REMOVE,  9'd0,   32'd5);
    send_req(ilse_pkg::OP_DELETE,  9'd3,   '0);
    send_req(ilse_pkg::OP_POP,     9'd0,   '0);
    send_req(ilse_pkg::OP_FIND,    9'd0,   32'hFFFF_FFFF);
    send_req(ilse_pkg::OP_READ,    9'd255, '0);

    // Sender holds off until the block has answered everything
    wait_replies();

    // Random phases
    while (n_sent < ITEM_TARGET) begin
      calm         = (n_sent + CALM_TAIL >= ITEM_TARGET);
      tx_idle_pct  = $urandom_range(0, 2) * 25;
      rx_stall_pct = $urandom_range(0, 2) * 8;
      if ((!filled || $urandom_range(0, 11) == 0) && n_sent + CALM_TAIL < ITEM_TARGET) begin
        fill_store();
        filled = 1'b1;
      end
      ph  = phase_e'($urandom_range(0, 2));
      len = $urandom_range(20, 80);
      // keep long lists from dominating the run time
      if (sb.n_entries > 160) ph = PH_SHRINK;
      while (len != 0 && n_sent < ITEM_TARGET) begin
        if (n_sent + CALM_TAIL >= ITEM_TARGET) calm = 1'b1;
        send_random(ph);
        len--;
      end
      if ($urandom_range(0, 3) == 0) wait_replies();
    end

    // Drain and let the block settle
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DEPTH + 16) @(posedge clk_i);

    if (sb.n_faults == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
